// File: rtl/min_tracking_stack_top_defines.svh
// Assertion macros for the min tracking stack.
// Used by min_tracking_stack_top; each macro expects a clock named clk and a reset rst.
`ifndef MIN_TRACKING_STACK_TOP_DEFINES_SVH
`define MIN_TRACKING_STACK_TOP_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define MTS_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("min tracking stack assertion failed");

// Next-cycle implication, disabled during reset.
`define MTS_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("min tracking stack assertion failed");

`endif

// File: rtl/mts_pkg.sv
// Shared types and codes for the min tracking stack.
// No dependencies; imported by min_tracking_stack_top.
package mts_pkg;

  localparam logic [1:0] CMD_READ = 2'd0;
  localparam logic [1:0] CMD_PUSH = 2'd1;
  localparam logic [1:0] CMD_POP  = 2'd2;

  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_EMPTY = 2'd1;
  localparam logic [1:0] STATUS_FULL  = 2'd2;

  localparam logic signed [31:0] EMPTY_MIN = 32'sh7fffffff;

  typedef struct packed {
    logic [1:0]         command;
    logic signed [31:0] value;
  } mts_cmd_t;

  typedef struct packed {
    logic signed [31:0] top_value;
    logic signed [31:0] min_value;
    logic [6:0]         entry_count;
    logic [1:0]         status;
  } mts_rsp_t;

endpackage

// File: rtl/mts_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies; instantiated by min_tracking_stack_top.
module mts_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: rtl/min_tracking_stack_top.sv
// Min tracking stack: signed 32-bit stack that reports its running minimum.
// Read, push, refused commands and a pop down to zero entries finish in the accept cycle;
// the result beat is registered in the cycle after. A pop that keeps entries passes through
// TOP to fetch the new top, and a pop that removes the minimum then walks the entries left
// in SCAN, one entry per cycle through the stack RAM read port. Reset (rst, synchronous)
// empties the stack and sets the minimum to 0x7fffffff; the RAM itself is not cleared.
//
// Depends on mts_pkg, mts_ram and min_tracking_stack_top_defines.svh.
`include "min_tracking_stack_top_defines.svh"

module min_tracking_stack_top
  import mts_pkg::*;
#(
  parameter int DEPTH = 64
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     cmd_valid,
  output logic     cmd_ready,
  input  mts_cmd_t cmd,
  output logic     rsp_valid,
  input  logic     rsp_ready,
  output mts_rsp_t rsp
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);

  // The sequencer idles while waiting for a command, passes through TOP to take the new
  // top entry after a pop, and walks the stored entries in SCAN when the popped entry was
  // the minimum.
  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_TOP  = 3'b010,
    ST_SCAN = 3'b100
  } state_t;

  state_t             state, state_next;
  logic [CW-1:0]      count, count_next;
  logic signed [31:0] top, top_next;
  logic signed [31:0] rmin, rmin_next;
  logic               need_scan, need_scan_next;
  logic [CW-1:0]      idx, idx_next;
  logic               pend, pend_next;
  logic               rsp_valid_next;
  mts_rsp_t           rsp_next;

  logic               cmd_fire;
  logic               ram_we;
  logic [AW-1:0]      ram_raddr;
  logic [31:0]        ram_rdata;
  logic signed [31:0] cmp_a;
  logic               cmp_lt;
  logic [CW+6:0]      count_wide;

  // A new command is taken only when the sequencer is idle and the result register is
  // free or being emptied in this same cycle, so a finishing item always has room.
  assign cmd_ready = (state == ST_IDLE) && (!rsp_valid || rsp_ready);
  assign cmd_fire  = cmd_valid && cmd_ready;

  // The one shared signed comparator: against the incoming value for a push and against
  // each entry read back during the rescan. The minimum register is the accumulator.
  assign cmp_a  = (state == ST_SCAN) ? $signed(ram_rdata) : cmd.value;
  assign cmp_lt = cmp_a < rmin;

  assign ram_we = cmd_fire && (cmd.command == CMD_PUSH) && (count < FULL_COUNT);

  // The count reported on the result is the low seven bits of the fill count.
  assign count_wide = {7'd0, count_next};

  mts_ram #(
    .WIDTH(32),
    .DEPTH(DEPTH)
  ) u_store (
    .clk  (clk),
    .we   (ram_we),
    .waddr(count[AW-1:0]),
    .wdata(cmd.value),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  always_comb begin
    state_next     = state;
    count_next     = count;
    top_next       = top;
    rmin_next      = rmin;
    need_scan_next = need_scan;
    idx_next       = idx;
    pend_next      = pend;
    rsp_valid_next = rsp_valid && !rsp_ready;
    rsp_next       = rsp;
    ram_raddr      = idx[AW-1:0];

    unique case (state)
      ST_IDLE: begin
        // After a pop the new top sits two below the current count.
        ram_raddr = AW'(count - CW'(2));
        if (cmd_fire) begin
          rsp_valid_next       = 1'b1;
          rsp_next.top_value   = top;
          rsp_next.min_value   = rmin;
          rsp_next.status      = STATUS_OK;
          case (cmd.command)
            CMD_PUSH: begin
              if (count >= FULL_COUNT) begin
                rsp_next.status = STATUS_FULL;
              end else begin
                count_next = count + CW'(1);
                top_next   = cmd.value;
                if (cmp_lt) begin
                  rmin_next = cmd.value;
                end
                rsp_next.top_value = cmd.value;
                rsp_next.min_value = cmp_lt ? cmd.value : rmin;
              end
            end
            CMD_POP: begin
              if (count == '0) begin
                rsp_next.status = STATUS_EMPTY;
              end else if (count == CW'(1)) begin
                // Popping the last entry leaves an empty stack.
                count_next         = '0;
                top_next           = '0;
                rmin_next          = EMPTY_MIN;
                rsp_next.top_value = '0;
                rsp_next.min_value = EMPTY_MIN;
              end else begin
                count_next     = count - CW'(1);
                need_scan_next = (top == rmin);
                rsp_valid_next = 1'b0;
                state_next     = ST_TOP;
              end
            end
            default: begin
              // Read, and the unused code that behaves as a read.
            end
          endcase
          rsp_next.entry_count = count_wide[6:0];
        end
      end

      ST_TOP: begin
        top_next = $signed(ram_rdata);
        if (need_scan) begin
          rmin_next  = EMPTY_MIN;
          idx_next   = '0;
          pend_next  = 1'b0;
          state_next = ST_SCAN;
        end else begin
          rsp_valid_next       = 1'b1;
          rsp_next.top_value   = $signed(ram_rdata);
          rsp_next.min_value   = rmin;
          rsp_next.entry_count = count_wide[6:0];
          rsp_next.status      = STATUS_OK;
          state_next           = ST_IDLE;
        end
      end

      ST_SCAN: begin
        // Issue one read per cycle while entries remain; its data is compared in the next cycle.
        if (idx < count) begin
          idx_next  = idx + CW'(1);
          pend_next = 1'b1;
        end else begin
          pend_next = 1'b0;
        end
        if (pend && cmp_lt) begin
          rmin_next = $signed(ram_rdata);
        end
        if (!pend && (idx == count)) begin
          rsp_valid_next       = 1'b1;
          rsp_next.top_value   = top;
          rsp_next.min_value   = rmin;
          rsp_next.entry_count = count_wide[6:0];
          rsp_next.status      = STATUS_OK;
          state_next           = ST_IDLE;
        end
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      count     <= '0;
      top       <= '0;
      rmin      <= EMPTY_MIN;
      need_scan <= 1'b0;
      idx       <= '0;
      pend      <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      state     <= state_next;
      count     <= count_next;
      top       <= top_next;
      rmin      <= rmin_next;
      need_scan <= need_scan_next;
      idx       <= idx_next;
      pend      <= pend_next;
      rsp_valid <= rsp_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    rsp <= rsp_next;
  end

  // The fill count never passes the stack depth.
  `MTS_ASSERT_IMP(a_count_range, 1'b1, count <= FULL_COUNT)
  // The rescan never reads past the entries that remain.
  `MTS_ASSERT_IMP(a_scan_bound, state == ST_SCAN, idx <= count)
  // An idle empty stack shows a zero top and the empty minimum.
  `MTS_ASSERT_IMP(a_empty_view, (state == ST_IDLE) && (count == '0),
                  (top == '0) && (rmin == EMPTY_MIN))
  // An accepted command either has its result ready or keeps the sequencer busy.
  `MTS_ASSERT_NXT(a_cmd_progress, cmd_fire, rsp_valid || (state != ST_IDLE))

endmodule

// File: test/min_tracking_stack_top_tb.sv
// Self-checking testbench for min_tracking_stack_top: random and directed stack commands.
// Depends on mts_pkg and the min_tracking_stack_top RTL; needs nothing else at run time.
`timescale 1ns / 1ps

module min_tracking_stack_top_tb;
  import mts_pkg::*;

  localparam int STACK_DEPTH = 64;
  // Command code 3 is unused by the block and must behave as a read.
  localparam logic [1:0] CMD_SPARE = 2'd3;
  // Slowest legal run is well under a fifth of this, even with the heaviest stalls.
  localparam int RUN_LIMIT = 600000;
  localparam int PRINT_CAP = 200;

  logic     clk;
  logic     rst;
  logic     cmd_valid;
  logic     cmd_ready;
  mts_cmd_t cmd;
  logic     rsp_valid;
  logic     rsp_ready;
  mts_rsp_t rsp;

  // Per-cycle chances, in percent, that the sender idles and the receiver stalls.
  int cmd_idle_pct = 0;
  int rsp_stall_pct = 0;
  // Set by the main sequence to make the receiver hold off; its value sets the length.
  int hold_len = 0;
  int cycle_count;
  // Direction of the random walk over the stack depth: mostly pushes or mostly pops.
  bit climbing = 1'b1;

  // Keeps a shadow copy of the stack, predicts each response beat and checks
  // the beats that come back, oldest expectation first.
  class stack_scoreboard;
    logic signed [31:0] store [STACK_DEPTH];
    int                 depth;
    logic signed [31:0] low_mark;
    mts_rsp_t           expected_rsps [$];
    int                 mismatch_count;
    int                 beats_seen;

    function new();
      depth = 0;
      low_mark = EMPTY_MIN;
      mismatch_count = 0;
      beats_seen = 0;
    endfunction

    task report(string msg);
      if (mismatch_count < PRINT_CAP) $display("%0t mismatch: %s", $realtime, msg);
      mismatch_count++;
    endtask

    // Applies one command to the shadow stack and returns the response it should produce.
    function mts_rsp_t apply_command(mts_cmd_t c);
      mts_rsp_t           r;
      logic signed [31:0] popped;
      r = '0;
      r.status = STATUS_OK;
      case (c.command)
        CMD_PUSH: begin
          if (depth == STACK_DEPTH) begin
            r.status = STATUS_FULL;
          end else begin
            store[depth] = c.value;
            depth++;
            if ($signed(c.value) < $signed(low_mark)) low_mark = c.value;
          end
        end
        CMD_POP: begin
          if (depth == 0) begin
            r.status = STATUS_EMPTY;
          end else begin
            popped = store[depth-1];
            depth--;
            // Losing the minimum forces a rescan of what is left.
            if (popped == low_mark) begin
              low_mark = EMPTY_MIN;
              for (int i = 0; i < depth; i++) begin
                if ($signed(store[i]) < $signed(low_mark)) low_mark = store[i];
              end
            end
          end
        end
        default: begin
        end
      endcase
      r.top_value = (depth > 0) ? store[depth-1] : '0;
      r.min_value = (depth > 0) ? low_mark : EMPTY_MIN;
      r.entry_count = 7'(depth);
      return r;
    endfunction

    function void note_cmd(mts_cmd_t c);
      expected_rsps.push_back(apply_command(c));
    endfunction

    task check_rsp(mts_rsp_t got);
      mts_rsp_t want;
      beats_seen++;
      if (expected_rsps.size() == 0) begin
        report($sformatf("beat %0d arrived with nothing expected: %h", beats_seen, got));
      end else begin
        want = expected_rsps.pop_front();
        if (got.top_value !== want.top_value)
          report($sformatf("beat %0d top_value got %h want %h",
                           beats_seen, got.top_value, want.top_value));
        if (got.min_value !== want.min_value)
          report($sformatf("beat %0d min_value got %h want %h",
                           beats_seen, got.min_value, want.min_value));
        if (got.entry_count !== want.entry_count)
          report($sformatf("beat %0d entry_count got %0d want %0d",
                           beats_seen, got.entry_count, want.entry_count));
        if (got.status !== want.status)
          report($sformatf("beat %0d status got %0d want %0d",
                           beats_seen, got.status, want.status));
      end
    endtask

    function int pending();
      return expected_rsps.size();
    endfunction
  endclass

  stack_scoreboard sb;

  min_tracking_stack_top #(
    .DEPTH(STACK_DEPTH)
  ) u_top (
    .clk      (clk),
    .rst      (rst),
    .cmd_valid(cmd_valid),
    .cmd_ready(cmd_ready),
    .cmd      (cmd),
    .rsp_valid(rsp_valid),
    .rsp_ready(rsp_ready),
    .rsp      (rsp)
  );

  // 4 ns clock.
  initial clk = 1'b0;
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Both handshakes are observed at the rising edge. The command is noted
  // before the response is checked, so a same-edge pair would still line up.
  always @(posedge clk) begin
    if (!rst) begin
      if (cmd_valid && cmd_ready) sb.note_cmd(cmd);
      if (rsp_valid && rsp_ready) sb.check_rsp(rsp);
    end
  end

  // Receiver: random stalls at the set rate, or a long hold-off when asked.
  // It changes rsp_ready only at falling edges.
  initial begin
    rsp_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_len > 0) begin
        rsp_ready <= 1'b0;
        repeat (hold_len) @(negedge clk);
        hold_len = 0;
      end else begin
        rsp_ready <= ($urandom_range(99) >= rsp_stall_pct);
      end
    end
  end

  // Watchdog: a hung block ends the run as a failure.
  initial begin
    cycle_count = 0;
    while (cycle_count < RUN_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("[min_tracking_stack_top] ERROR");
    $finish;
  end

  // Drops valid while idling n times. Every driving task starts and ends at a falling edge.
  task automatic sender_idle(input int n);
    repeat (n) begin
      cmd_valid <= 1'b0;
      @(negedge clk);
    end
  endtask

  // Offers one command beat and holds it until the block takes it.
  task automatic send_cmd(input logic [1:0] op, input logic signed [31:0] val);
    while ($urandom_range(99) < cmd_idle_pct) sender_idle(1);
    cmd_valid <= 1'b1;
    cmd <= '{command: op, value: val};
    do @(posedge clk); while (!cmd_ready);
    @(negedge clk);
  endtask

  // Pauses the sender until every predicted response beat has come back.
  task automatic wait_drained();
    sender_idle(1);
    while (sb.pending() != 0) @(negedge clk);
  endtask

  // Push values lean toward a narrow band so that duplicates of the minimum
  // are common, with the extremes and fully random words mixed in.
  function automatic logic signed [31:0] pick_value();
    case ($urandom_range(9))
      0, 1, 2, 3: return 32'(int'($urandom_range(8)) - 4);
      4: begin
        case ($urandom_range(4))
          0:       return 32'sh80000000;
          1:       return EMPTY_MIN;
          2:       return 32'sd0;
          3:       return -32'sd1;
          default: return 32'sd1;
        endcase
      end
      default: return $urandom();
    endcase
  endfunction

  // Random walk over the stack depth. While climbing most commands are pushes,
  // while descending most are pops; the direction flips at the full and empty
  // ends (often after a few refused commands) and now and then midway.
  task automatic run_random(input int n);
    int                 r;
    logic [1:0]         op;
    logic signed [31:0] val;
    for (int k = 0; k < n; k++) begin
      r = $urandom_range(99);
      if (r < 6) op = CMD_READ;
      else if (r < 9) op = CMD_SPARE;
      else op = ($urandom_range(99) < (climbing ? 78 : 22)) ? CMD_PUSH : CMD_POP;
      // Read and pop ignore the value, so it carries random noise there.
      val = (op == CMD_PUSH) ? pick_value() : $urandom();
      send_cmd(op, val);
      if (sb.depth == STACK_DEPTH && $urandom_range(2) == 0) climbing = 1'b0;
      else if (sb.depth == 0 && $urandom_range(2) == 0) climbing = 1'b1;
      else if ($urandom_range(59) == 0) climbing = !climbing;
    end
  endtask

  initial begin
    sb = new();
    rst = 1'b1;
    cmd_valid = 1'b0;
    cmd = '0;
    repeat (10) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed beats, no idling: reads and the spare code on an empty stack, a
    // refused pop, the value extremes, a pop that removes the minimum and
    // forces a rescan, a pop that empties the stack, and a duplicated minimum.
    send_cmd(CMD_READ, 32'sd0);
    send_cmd(CMD_SPARE, -32'sd1);
    send_cmd(CMD_POP, 32'sh12345678);
    send_cmd(CMD_PUSH, EMPTY_MIN);
    send_cmd(CMD_PUSH, 32'sh80000000);
    send_cmd(CMD_PUSH, 32'sd0);
    send_cmd(CMD_PUSH, -32'sd1);
    send_cmd(CMD_READ, -32'sd1);
    send_cmd(CMD_POP, 32'sd0);
    send_cmd(CMD_POP, 32'sd0);
    send_cmd(CMD_POP, 32'sd0);
    send_cmd(CMD_POP, 32'sd0);
    send_cmd(CMD_PUSH, 32'sd5);
    send_cmd(CMD_PUSH, 32'sd5);
    send_cmd(CMD_POP, 32'sd0);
    send_cmd(CMD_POP, 32'sd0);
    send_cmd(CMD_PUSH, 32'sh55555555);
    send_cmd(CMD_PUSH, 32'shaaaaaaaa);
    send_cmd(CMD_POP, 32'sh55555555);
    send_cmd(CMD_POP, 32'shaaaaaaaa);

    // Fill to the top with random values, bounce off it twice, then unload
    // down past empty so both refusals are seen from a full stack.
    while (sb.depth < STACK_DEPTH) send_cmd(CMD_PUSH, pick_value());
    repeat (2) send_cmd(CMD_PUSH, pick_value());
    repeat (STACK_DEPTH + 1) send_cmd(CMD_POP, $urandom());
    wait_drained();

    // Back-pressure: the receiver holds off for a long stretch while the
    // sender keeps offering beats, so the block backs up and stalls its input.
    climbing = 1'b1;
    hold_len = 400;
    run_random(60);
    wait_drained();

    // Random traffic under each idling pattern.
    run_random(268);
    wait_drained();

    cmd_idle_pct = 63;
    rsp_stall_pct = 0;
    run_random(268);
    wait_drained();

    cmd_idle_pct = 0;
    rsp_stall_pct = 63;
    run_random(268);
    wait_drained();

    cmd_idle_pct = 38;
    rsp_stall_pct = 38;
    run_random(268);
    wait_drained();

    // Give the block time to show any stray response beat; the wait outlasts a full rescan.
    repeat (100) @(negedge clk);

    if (sb.mismatch_count == 0) begin
      $display("[min_tracking_stack_top] OK");
    end else begin
      $display("[min_tracking_stack_top] ERROR");
    end
    $finish;
  end

endmodule
